@@ rtl/psf_pkg.sv @@
`default_nettype none
package psf_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned NUM_ST  = 6;
  localparam int unsigned NUM_EV  = 15;

  // session states
  localparam logic [STATE_W-1:0] ST_IDLE        = 3'd0;
  localparam logic [STATE_W-1:0] ST_CONNECT     = 3'd1;
  localparam logic [STATE_W-1:0] ST_ACTIVE      = 3'd2;
  localparam logic [STATE_W-1:0] ST_OPENSENT    = 3'd3;
  localparam logic [STATE_W-1:0] ST_OPENCONFIRM = 3'd4;
  localparam logic [STATE_W-1:0] ST_ESTABLISHED = 3'd5;
  localparam logic [3:0]         ST_KEEP        = 4'd7;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_INIT      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_CLOSE     = 4'd2;
  localparam logic [ACT_W-1:0] ACT_OPEN      = 4'd3;
  localparam logic [ACT_W-1:0] ACT_NOTIFY    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_RETRYTMR  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_RETRYNOW  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_KEEPALIVE = 4'd7;
  localparam logic [ACT_W-1:0] ACT_HOLDRST   = 4'd8;
  localparam logic [ACT_W-1:0] ACT_UPDATE    = 4'd9;

  // timer selects
  localparam logic [1:0] TMR_NONE      = 2'd0;
  localparam logic [1:0] TMR_CONNECT   = 2'd1;
  localparam logic [1:0] TMR_KEEPALIVE = 2'd2;
  localparam logic [1:0] TMR_HOLD      = 2'd3;

  // messages
  localparam logic [1:0] MSG_NONE      = 2'd0;
  localparam logic [1:0] MSG_OPEN      = 2'd1;
  localparam logic [1:0] MSG_KEEPALIVE = 2'd2;

  // configuration register indexes and reset values
  localparam logic [1:0] REG_CONNECT_RETRY = 2'd0;
  localparam logic [1:0] REG_KEEPALIVE     = 2'd1;
  localparam logic [1:0] REG_HOLD          = 2'd2;

  localparam logic [TIME_W-1:0] CONNECT_RETRY_RST = 16'd120;
  localparam logic [TIME_W-1:0] KEEPALIVE_RST     = 16'd30;
  localparam logic [TIME_W-1:0] HOLD_RST          = 16'd90;

  // entry: action in the high nibble, next state in the low nibble
  localparam logic [7:0] TRANS [0:NUM_ST-1][0:NUM_EV-1] = '{
    '{8'h11, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
      8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07},
    '{8'h07, 8'h20, 8'h33, 8'h20, 8'h52, 8'h20, 8'h61, 8'h20,
      8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h07, 8'h20},
    '{8'h07, 8'h20, 8'h33, 8'h20, 8'h07, 8'h20, 8'h61, 8'h20,
      8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h07, 8'h20},
    '{8'h07, 8'h40, 8'h40, 8'h52, 8'h40, 8'h20, 8'h40, 8'h40,
      8'h40, 8'h74, 8'h40, 8'h40, 8'h20, 8'h07, 8'h40},
    '{8'h07, 8'h40, 8'h40, 8'h40, 8'h40, 8'h52, 8'h40, 8'h40,
      8'h74, 8'h40, 8'h05, 8'h40, 8'h20, 8'h07, 8'h40},
    '{8'h07, 8'h40, 8'h40, 8'h40, 8'h40, 8'h20, 8'h40, 8'h40,
      8'h75, 8'h40, 8'h85, 8'h85, 8'h20, 8'h95, 8'h40}
  };

  typedef struct packed {
    logic [TIME_W-1:0] connect_retry_time;
    logic [TIME_W-1:0] keepalive_time;
    logic [TIME_W-1:0] hold_period;
  } psf_cfg_t;

  typedef struct packed {
    logic [1:0]         send_message;
    logic [TIME_W-1:0]  timer_load_value;
    logic [1:0]         timer_start_select;
    logic [1:0]         timer_stop_select;
    logic               disconnect_request;
    logic               connect_request;
    logic [ACT_W-1:0]   action_code;
    logic [STATE_W-1:0] new_state;
  } psf_result_t;

endpackage
`default_nettype wire

@@ rtl/psf_decode.sv @@
`default_nettype none
module psf_decode (
  input  wire logic [psf_pkg::STATE_W-1:0] state,
  input  wire logic [psf_pkg::EVENT_W-1:0] event_code,
  input  wire logic                        link_up,
  input  wire psf_pkg::psf_cfg_t           cfg,
  output psf_pkg::psf_result_t             res
);
  import psf_pkg::*;

  logic [STATE_W-1:0] st;
  logic [7:0]         entry;

  always_comb begin
    // out-of-range state falls back to idle
    st = (state <= ST_ESTABLISHED) ? state : ST_IDLE;
    entry = {ACT_NONE, ST_KEEP};
    if (event_code < EVENT_W'(NUM_EV)) begin
      entry = TRANS[st][event_code];
    end

    res = '0;
    res.action_code = entry[7:4];
    res.new_state   = (entry[3:0] == ST_KEEP) ? st : entry[STATE_W-1:0];

    unique case (entry[7:4])
      ACT_INIT: begin
        if (!link_up) begin
          res.connect_request    = 1'b1;
          res.timer_start_select = TMR_CONNECT;
          res.timer_load_value   = cfg.connect_retry_time;
        end
      end
      ACT_CLOSE: begin
        res.disconnect_request = link_up;
      end
      ACT_OPEN: begin
        res.send_message      = MSG_OPEN;
        res.timer_stop_select = TMR_CONNECT;
      end
      ACT_RETRYTMR: begin
        res.timer_start_select = TMR_CONNECT;
        res.timer_load_value   = cfg.connect_retry_time;
      end
      ACT_RETRYNOW: begin
        res.disconnect_request = 1'b1;
        res.connect_request    = 1'b1;
        res.timer_start_select = TMR_CONNECT;
        res.timer_load_value   = cfg.connect_retry_time;
      end
      ACT_KEEPALIVE: begin
        res.send_message       = MSG_KEEPALIVE;
        res.timer_stop_select  = TMR_KEEPALIVE;
        res.timer_start_select = TMR_KEEPALIVE;
        res.timer_load_value   = cfg.keepalive_time;
      end
      ACT_HOLDRST: begin
        res.timer_stop_select  = TMR_HOLD;
        res.timer_start_select = TMR_HOLD;
        res.timer_load_value   = cfg.hold_period;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/peer_session_fsm.sv @@
`default_nettype none
// Session state machine for a BGP-style peering protocol.
// Input stream: each transfer carries one event and the transport-connected
// flag. The event looks up a fixed transition table for the current session
// state; the result gives the next state, the action code and the transport,
// timer and message commands for that event.
// Output stream: exactly one result transfer per input transfer, in order.
// Latency: the result is valid on the cycle after the input transfer.
// Throughput: one event per cycle; the output register frees in the same
// cycle that its result is taken, so a new event is accepted alongside.
// When the receiver stalls, the held result stays in the output register and
// in_tready drops until it is taken.
// Configuration: cfg_we writes cfg_wdata into the timer duration selected by
// cfg_index (0 connect retry, 1 keepalive, 2 hold); index 3 is ignored.
// Write only while no result is pending.
// Reset (synchronous, rst_n low): state returns to idle, the output register
// empties and the durations return to 120, 30 and 90.
module peer_session_fsm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] event_code, [4] link_up
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] new_state, [6:3] action_code, [7] connect_request,
  // [8] disconnect_request, [10:9] timer_stop_select,
  // [12:11] timer_start_select, [28:13] timer_load_value, [30:29] send_message
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import psf_pkg::*;

  psf_cfg_t           cfg_r;
  logic [STATE_W-1:0] state_r;
  logic               out_valid_r;
  psf_result_t        out_r;
  psf_result_t        res;
  logic               in_xfer;

  psf_decode u_decode (
    .state      (state_r),
    .event_code (in_tdata[EVENT_W-1:0]),
    .link_up    (in_tdata[EVENT_W]),
    .cfg        (cfg_r),
    .res        (res)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_retry_time <= CONNECT_RETRY_RST;
      cfg_r.keepalive_time     <= KEEPALIVE_RST;
      cfg_r.hold_period        <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONNECT_RETRY: cfg_r.connect_retry_time <= cfg_wdata;
        REG_KEEPALIVE:     cfg_r.keepalive_time     <= cfg_wdata;
        REG_HOLD:          cfg_r.hold_period        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= res.new_state;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load on every accepted transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= res;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none
module tb_top;
  import psf_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_START, EV_STOP, EV_CONN_OPEN, EV_CONN_CLOSED, EV_CONN_FAILED, EV_CONN_FATAL,
    EV_RETRY_EXP, EV_HOLD_EXP, EV_KA_EXP, EV_OPEN_RCVD, EV_KA_RCVD, EV_UPDATE_RCVD,
    EV_NOTIF_RCVD, EV_SEND_UPDATE, EV_MSG_ERR, EV_UNUSED
  } session_event_t;

  class session_scoreboard;
    logic [STATE_W-1:0] cur_state;
    logic [TIME_W-1:0]  retry_dur;
    logic [TIME_W-1:0]  ka_dur;
    logic [TIME_W-1:0]  hold_dur;
    psf_result_t        pending[$];
    int                 errors;

    function new();
      cur_state = ST_IDLE;
      retry_dur = CONNECT_RETRY_RST;
      ka_dur    = KEEPALIVE_RST;
      hold_dur  = HOLD_RST;
      errors    = 0;
    endfunction

    function void set_duration(logic [1:0] idx, logic [TIME_W-1:0] val);
      case (idx)
        REG_CONNECT_RETRY: retry_dur = val;
        REG_KEEPALIVE:     ka_dur    = val;
        REG_HOLD:          hold_dur  = val;
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function string fmt(psf_result_t r);
      return $sformatf("st=%0d act=%0d conn=%0d disc=%0d stop=%0d start=%0d load=%0d msg=%0d",
                       r.new_state, r.action_code, r.connect_request, r.disconnect_request,
                       r.timer_stop_select, r.timer_start_select, r.timer_load_value,
                       r.send_message);
    endfunction

    // next state and action for one event; unlisted pairs take the state's default, which holds only in idle
    function void lookup(input logic [STATE_W-1:0] st, input logic [EVENT_W-1:0] ev,
                         output logic [ACT_W-1:0] act, output logic [STATE_W-1:0] nxt);
      logic [STATE_W-1:0] eff;
      eff = (st <= ST_ESTABLISHED) ? st : ST_IDLE;
      nxt = eff;
      act = ACT_NONE;
      if (ev == EV_UNUSED) return;
      case (eff)
        ST_CONNECT, ST_ACTIVE: begin
          case (ev)
            EV_START, EV_SEND_UPDATE: ;
            EV_CONN_OPEN: begin act = ACT_OPEN; nxt = ST_OPENSENT; end
            EV_CONN_FAILED: begin
              if (eff == ST_CONNECT) begin act = ACT_RETRYTMR; nxt = ST_ACTIVE; end
            end
            EV_RETRY_EXP: begin act = ACT_RETRYNOW; nxt = ST_CONNECT; end
            default: begin act = ACT_CLOSE; nxt = ST_IDLE; end
          endcase
        end
        ST_OPENSENT: begin
          case (ev)
            EV_START, EV_SEND_UPDATE: ;
            EV_CONN_CLOSED: begin act = ACT_RETRYTMR; nxt = ST_ACTIVE; end
            EV_CONN_FATAL, EV_NOTIF_RCVD: begin act = ACT_CLOSE; nxt = ST_IDLE; end
            EV_OPEN_RCVD: begin act = ACT_KEEPALIVE; nxt = ST_OPENCONFIRM; end
            default: begin act = ACT_NOTIFY; nxt = ST_IDLE; end
          endcase
        end
        ST_OPENCONFIRM: begin
          case (ev)
            EV_START, EV_SEND_UPDATE: ;
            EV_CONN_FATAL: begin act = ACT_RETRYTMR; nxt = ST_ACTIVE; end
            EV_KA_EXP: begin act = ACT_KEEPALIVE; nxt = ST_OPENCONFIRM; end
            EV_KA_RCVD: begin act = ACT_NONE; nxt = ST_ESTABLISHED; end
            EV_NOTIF_RCVD: begin act = ACT_CLOSE; nxt = ST_IDLE; end
            default: begin act = ACT_NOTIFY; nxt = ST_IDLE; end
          endcase
        end
        ST_ESTABLISHED: begin
          case (ev)
            EV_START: ;
            EV_CONN_FATAL, EV_NOTIF_RCVD: begin act = ACT_CLOSE; nxt = ST_IDLE; end
            EV_KA_EXP: begin act = ACT_KEEPALIVE; nxt = ST_ESTABLISHED; end
            EV_KA_RCVD, EV_UPDATE_RCVD: begin act = ACT_HOLDRST; nxt = ST_ESTABLISHED; end
            EV_SEND_UPDATE: begin act = ACT_UPDATE; nxt = ST_ESTABLISHED; end
            default: begin act = ACT_NOTIFY; nxt = ST_IDLE; end
          endcase
        end
        default: begin
          if (ev == EV_START) begin act = ACT_INIT; nxt = ST_CONNECT; end
        end
      endcase
    endfunction

    function void note_event(logic [EVENT_W-1:0] ev, logic up);
      psf_result_t        r;
      logic [ACT_W-1:0]   act;
      logic [STATE_W-1:0] nxt;
      lookup(cur_state, ev, act, nxt);
      r = '0;
      r.new_state   = nxt;
      r.action_code = act;
      case (act)
        ACT_INIT: begin
          // already connected: no command
          if (!up) begin
            r.connect_request    = 1'b1;
            r.timer_start_select = TMR_CONNECT;
            r.timer_load_value   = retry_dur;
          end
        end
        ACT_CLOSE: r.disconnect_request = up;
        ACT_OPEN: begin
          r.send_message      = MSG_OPEN;
          r.timer_stop_select = TMR_CONNECT;
        end
        ACT_RETRYTMR: begin
          r.timer_start_select = TMR_CONNECT;
          r.timer_load_value   = retry_dur;
        end
        ACT_RETRYNOW: begin
          r.disconnect_request = 1'b1;
          r.connect_request    = 1'b1;
          r.timer_start_select = TMR_CONNECT;
          r.timer_load_value   = retry_dur;
        end
        ACT_KEEPALIVE: begin
          r.send_message       = MSG_KEEPALIVE;
          r.timer_stop_select  = TMR_KEEPALIVE;
          r.timer_start_select = TMR_KEEPALIVE;
          r.timer_load_value   = ka_dur;
        end
        ACT_HOLDRST: begin
          r.timer_stop_select  = TMR_HOLD;
          r.timer_start_select = TMR_HOLD;
          r.timer_load_value   = hold_dur;
        end
        default: ;
      endcase
      cur_state = nxt;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] data);
      psf_result_t got;
      psf_result_t want;
      got = psf_result_t'(data[30:0]);
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: %s", fmt(got)));
        return;
      end
      want = pending.pop_front();
      if (data[31] !== 1'b0 ||
          got.new_state !== want.new_state ||
          got.action_code !== want.action_code ||
          got.connect_request !== want.connect_request ||
          got.disconnect_request !== want.disconnect_request ||
          got.timer_stop_select !== want.timer_stop_select ||
          got.timer_start_select !== want.timer_start_select ||
          got.timer_load_value !== want.timer_load_value ||
          got.send_message !== want.send_message)
        flag($sformatf("mismatch\n  expected: %s\n  actual:   %s (pad %b)",
                       fmt(want), fmt(got), data[31]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [3:0] event_code, [4] link_up
  logic        out_tvalid;
  logic        out_tready;
  // [2:0] new_state, [6:3] action_code, [7] connect_request,
  // [8] disconnect_request, [10:9] timer_stop_select,
  // [12:11] timer_start_select, [28:13] timer_load_value, [30:29] send_message
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  session_scoreboard sb;
  bit                steady = 1'b0;
  int                results_seen = 0;

  peer_session_fsm u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic offer(input logic [EVENT_W-1:0] ev, input logic up);
    int n;
    if (!steady && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata  <= {3'b000, up, ev};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_event(ev, up);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_duration(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_duration(idx, val);
  endtask

  // mostly the event that moves the session forward, some noise
  task automatic next_item(output logic [EVENT_W-1:0] ev, output logic up);
    int r;
    r  = $urandom_range(0, 99);
    up = 1'($urandom_range(0, 1));
    if (r < 25) begin
      ev = EVENT_W'($urandom_range(0, 15));
    end else begin
      case (sb.cur_state)
        ST_IDLE:        ev = EV_START;
        ST_CONNECT:     ev = (r < 60) ? EV_CONN_OPEN : (r < 80) ? EV_CONN_FAILED : EV_RETRY_EXP;
        ST_ACTIVE:      ev = (r < 70) ? EV_CONN_OPEN : EV_RETRY_EXP;
        ST_OPENSENT:    ev = (r < 80) ? EV_OPEN_RCVD : EV_CONN_CLOSED;
        ST_OPENCONFIRM: ev = (r < 75) ? EV_KA_RCVD : EV_KA_EXP;
        default: begin
          case ($urandom_range(0, 3))
            0:       ev = EV_KA_EXP;
            1:       ev = EV_KA_RCVD;
            2:       ev = EV_UPDATE_RCVD;
            default: ev = EV_SEND_UPDATE;
          endcase
        end
      endcase
    end
  endtask

  // receiver: random stall bursts, one long hold-off to back up the input
  initial begin : rx_ready_gen
    int  n;
    bit  held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 500) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (63) @(negedge clk);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      sb.check_result(out_tdata);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [EVENT_W-1:0] ev;
    logic               up;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk through every action, ignored and unused events
    offer(EV_STOP, 1'b0);
    offer(EV_UNUSED, 1'b1);
    offer(EV_START, 1'b1);
    offer(EV_CONN_FAILED, 1'b0);
    offer(EV_CONN_FAILED, 1'b1);
    offer(EV_RETRY_EXP, 1'b0);
    offer(EV_STOP, 1'b1);
    offer(EV_START, 1'b0);
    offer(EV_STOP, 1'b0);
    offer(EV_START, 1'b0);
    offer(EV_CONN_OPEN, 1'b1);
    offer(EV_OPEN_RCVD, 1'b1);
    offer(EV_KA_EXP, 1'b1);
    offer(EV_KA_RCVD, 1'b1);
    offer(EV_KA_RCVD, 1'b1);
    offer(EV_UPDATE_RCVD, 1'b1);
    offer(EV_SEND_UPDATE, 1'b1);
    offer(EV_KA_EXP, 1'b1);
    offer(EV_START, 1'b1);
    offer(EV_UNUSED, 1'b0);
    offer(EV_HOLD_EXP, 1'b1);
    offer(EV_START, 1'b0);
    offer(EV_CONN_OPEN, 1'b1);
    offer(EV_CONN_CLOSED, 1'b0);
    offer(EV_CONN_OPEN, 1'b1);
    offer(EV_NOTIF_RCVD, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin
            write_duration(REG_CONNECT_RETRY, 16'h0000);
            write_duration(REG_KEEPALIVE, 16'h0000);
            write_duration(REG_HOLD, 16'h0000);
          end
          2: begin
            write_duration(REG_CONNECT_RETRY, 16'hFFFF);
            write_duration(REG_KEEPALIVE, 16'hFFFF);
            write_duration(REG_HOLD, 16'hFFFF);
          end
          3: begin
            write_duration(REG_CONNECT_RETRY, 16'($urandom_range(0, 65535)));
            write_duration(REG_KEEPALIVE, 16'($urandom_range(0, 65535)));
            write_duration(REG_HOLD, 16'($urandom_range(0, 65535)));
          end
          4: begin
            write_duration(REG_HOLD, 16'($urandom_range(0, 65535)));
            write_duration(REG_UNUSED, 16'($urandom_range(0, 65535)));
          end
          default: begin
            write_duration(REG_CONNECT_RETRY, 16'hFFFF);
            write_duration(REG_KEEPALIVE, 16'h0000);
            write_duration(REG_HOLD, 16'($urandom_range(0, 65535)));
          end
        endcase
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == PHASES - 1 && i == 90) steady = 1'b1;
        next_item(ev, up);
        offer(ev, up);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag($sformatf("%0d expected results never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
